// ----- rtl/core/blp_pkg.sv -----
// Battery level line parser: shared types, phase codes and report prefix.
// No dependencies; used by every module of the block but blp_checker.
package blp_pkg;

    // Byte codes
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_COMMA = 8'd44;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_HT    = 8'd9;
    localparam logic [7:0] CHAR_VT    = 8'd11;
    localparam logic [7:0] CHAR_FF    = 8'd12;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    // Parse phases; codes below PH_LVL_START index the prefix text
    localparam logic [4:0] PH_LVL_START = 5'd11;
    localparam logic [4:0] PH_LVL_SIGN  = 5'd12;
    localparam logic [4:0] PH_LVL_DIG   = 5'd13;
    localparam logic [4:0] PH_FLG_START = 5'd14;
    localparam logic [4:0] PH_FLG_SIGN  = 5'd15;
    localparam logic [4:0] PH_FLG_DIG   = 5'd16;
    localparam logic [4:0] PH_DONE      = 5'd17;
    localparam logic [4:0] PH_FAIL      = 5'd18;

    // Range limits
    localparam logic [6:0] LEVEL_MAX     = 7'd100;
    localparam logic [6:0] LEVEL_SAT     = 7'd127;
    localparam logic [1:0] FLAG_SAT      = 2'd3;

    typedef struct packed {
        logic [4:0] phase;
        logic [6:0] lvl_mag;
        logic       lvl_neg;
        logic [1:0] flg_mag;
        logic       flg_neg;
    } t_parse_state;

    typedef struct packed {
        logic       present;
        logic [6:0] percent;
        logic       charging;
    } t_store;

    typedef struct packed {
        t_store store;
        logic   line_accepted;
        logic   first_detection;
    } t_result;

    localparam t_parse_state PARSE_IDLE = '{
        phase: 5'd0, lvl_mag: 7'd0, lvl_neg: 1'b0, flg_mag: 2'd0, flg_neg: 1'b0
    };

    // Prefix text "AT+BATTLVL=", one character per phase
    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h41; // A
            4'd1:    c = 8'h54; // T
            4'd2:    c = 8'h2B; // +
            4'd3:    c = 8'h42; // B
            4'd4:    c = 8'h41; // A
            4'd5:    c = 8'h54; // T
            4'd6:    c = 8'h54; // T
            4'd7:    c = 8'h4C; // L
            4'd8:    c = 8'h56; // V
            4'd9:    c = 8'h4C; // L
            4'd10:   c = 8'h3D; // =
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/blp_step.sv -----
// Battery level line parser: next-state and result logic for one byte.
// Depends on blp_pkg.
module blp_step #(
    parameter int LINE_CAPACITY = 64,
    parameter int LEN_W         = $clog2(LINE_CAPACITY)
) (
    input  logic [7:0]           i_byte,
    input  logic [LEN_W-1:0]     i_len,
    input  blp_pkg::t_parse_state i_ps,
    input  blp_pkg::t_store      i_store,
    output logic [LEN_W-1:0]     o_len,
    output blp_pkg::t_parse_state o_ps,
    output blp_pkg::t_store      o_store,
    output blp_pkg::t_result     o_result
);

    localparam logic [LEN_W:0] CAP_V = (LEN_W+1)'(LINE_CAPACITY);

    logic                  is_term;
    logic                  is_blank;
    logic                  is_digit;
    logic                  is_sign;
    logic [3:0]            digit;
    logic [10:0]           lvl_acc;
    logic [5:0]            flg_acc;
    logic [1:0]            flg_first;
    logic [LEN_W:0]        len_inc;
    logic                  done;
    logic                  lvl_ok;
    logic                  flg_ok;
    logic                  accepted;
    blp_pkg::t_parse_state adv;

    // Classify the byte
    assign is_term  = (i_byte == blp_pkg::CHAR_LF) || (i_byte == blp_pkg::CHAR_CR);
    assign is_blank = (i_byte == blp_pkg::CHAR_SPACE) || (i_byte == blp_pkg::CHAR_HT) ||
                      (i_byte == blp_pkg::CHAR_VT) || (i_byte == blp_pkg::CHAR_FF);
    assign is_digit = (i_byte >= blp_pkg::CHAR_ZERO) && (i_byte <= blp_pkg::CHAR_NINE);
    assign is_sign  = (i_byte == blp_pkg::CHAR_PLUS) || (i_byte == blp_pkg::CHAR_MINUS);
    assign digit    = i_byte[3:0];

    // Decimal accumulate: mag*10 + digit
    assign lvl_acc   = {1'b0, i_ps.lvl_mag, 3'b000} + {3'b000, i_ps.lvl_mag, 1'b0}
                     + {7'd0, digit};
    assign flg_acc   = {1'b0, i_ps.flg_mag, 3'b000} + {3'b000, i_ps.flg_mag, 1'b0}
                     + {2'd0, digit};
    assign flg_first = (digit > 4'd3) ? blp_pkg::FLAG_SAT : digit[1:0];

    // Advance the matcher by one character
    always_comb begin
        adv = i_ps;
        if (i_ps.phase < blp_pkg::PH_LVL_START) begin
            adv.phase = (i_byte == blp_pkg::prefix_char(i_ps.phase[3:0])) ?
                        i_ps.phase + 5'd1 : blp_pkg::PH_FAIL;
        end else begin
            case (i_ps.phase)
                blp_pkg::PH_LVL_START: begin
                    if (is_blank) begin
                        adv.phase = i_ps.phase;
                    end else if (is_sign) begin
                        adv.lvl_neg = (i_byte == blp_pkg::CHAR_MINUS);
                        adv.phase   = blp_pkg::PH_LVL_SIGN;
                    end else if (is_digit) begin
                        adv.lvl_mag = {3'd0, digit};
                        adv.phase   = blp_pkg::PH_LVL_DIG;
                    end else begin
                        adv.phase = blp_pkg::PH_FAIL;
                    end
                end
                blp_pkg::PH_FLG_START: begin
                    if (is_blank) begin
                        adv.phase = i_ps.phase;
                    end else if (is_sign) begin
                        adv.flg_neg = (i_byte == blp_pkg::CHAR_MINUS);
                        adv.phase   = blp_pkg::PH_FLG_SIGN;
                    end else if (is_digit) begin
                        adv.flg_mag = flg_first;
                        adv.phase   = blp_pkg::PH_FLG_DIG;
                    end else begin
                        adv.phase = blp_pkg::PH_FAIL;
                    end
                end
                blp_pkg::PH_LVL_SIGN: begin
                    if (is_digit) begin
                        adv.lvl_mag = {3'd0, digit};
                        adv.phase   = blp_pkg::PH_LVL_DIG;
                    end else begin
                        adv.phase = blp_pkg::PH_FAIL;
                    end
                end
                blp_pkg::PH_FLG_SIGN: begin
                    if (is_digit) begin
                        adv.flg_mag = flg_first;
                        adv.phase   = blp_pkg::PH_FLG_DIG;
                    end else begin
                        adv.phase = blp_pkg::PH_FAIL;
                    end
                end
                blp_pkg::PH_LVL_DIG: begin
                    if (is_digit) begin
                        adv.lvl_mag = (lvl_acc > {4'd0, blp_pkg::LEVEL_SAT}) ?
                                      blp_pkg::LEVEL_SAT : lvl_acc[6:0];
                    end else begin
                        adv.phase = (i_byte == blp_pkg::CHAR_COMMA) ?
                                    blp_pkg::PH_FLG_START : blp_pkg::PH_FAIL;
                    end
                end
                blp_pkg::PH_FLG_DIG: begin
                    if (is_digit) begin
                        adv.flg_mag = (flg_acc > {4'd0, blp_pkg::FLAG_SAT}) ?
                                      blp_pkg::FLAG_SAT : flg_acc[1:0];
                    end else begin
                        adv.phase = blp_pkg::PH_DONE;
                    end
                end
                blp_pkg::PH_DONE: begin
                    adv.phase = i_ps.phase;
                end
                default: begin
                    adv.phase = blp_pkg::PH_FAIL;
                end
            endcase
        end
    end

    // Line check at the terminator
    assign done     = (i_ps.phase == blp_pkg::PH_FLG_DIG) || (i_ps.phase == blp_pkg::PH_DONE);
    assign lvl_ok   = (i_ps.lvl_mag <= blp_pkg::LEVEL_MAX) &&
                      (!i_ps.lvl_neg || (i_ps.lvl_mag == 7'd0));
    assign flg_ok   = (i_ps.flg_mag <= 2'd1) && (!i_ps.flg_neg || (i_ps.flg_mag == 2'd0));
    assign len_inc  = {1'b0, i_len} + {{LEN_W{1'b0}}, 1'b1};
    assign accepted = is_term && (i_len != '0) && done && lvl_ok && flg_ok;

    // Select next line state: close a non-empty line, append or drop on overrun
    always_comb begin
        o_len   = i_len;
        o_ps    = i_ps;
        o_store = i_store;
        if (is_term) begin
            if (i_len != '0) begin
                o_len = '0;
                o_ps  = blp_pkg::PARSE_IDLE;
                if (accepted) begin
                    o_store.present  = 1'b1;
                    o_store.percent  = i_ps.lvl_mag;
                    o_store.charging = i_ps.flg_mag[0];
                end
            end
        end else if (len_inc < CAP_V) begin
            o_len = len_inc[LEN_W-1:0];
            o_ps  = adv;
        end else begin
            o_len = '0;
            o_ps  = blp_pkg::PARSE_IDLE;
        end
    end

    assign o_result.store           = o_store;
    assign o_result.line_accepted   = accepted;
    assign o_result.first_detection = accepted && !i_store.present;

endmodule

// ----- rtl/core/blp_out_reg.sv -----
// Battery level line parser: result register with valid/ready handshake.
// Depends on blp_pkg.
module blp_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  blp_pkg::t_result i_result,
    output logic             o_can_load,
    output logic             o_valid,
    input  logic             i_ready,
    output blp_pkg::t_result o_result
);

    logic             r_valid;
    blp_pkg::t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    // Hold result until taken; load a new one when free or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- rtl/core/battery_level_line_parser_top.sv -----
// Channel   | Handshake          | Payload
// ----------+--------------------+---------------------------------------------
// byte in   | i_valid / o_ready  | i_rx_byte
// result    | o_valid / i_ready  | o_present o_percent o_charging
//           |                    | o_line_accepted o_first_detection
//
// One byte per cycle sustained while the result side is ready; each request's
// result passes through the input register, then into the result register.
// Synchronous active-low reset clears the line state and stored report.
// A stall on the result side holds the result register; the input register
// still takes one more byte, then o_ready drops until the result is taken.
//
// Top level of the battery level line parser. Depends on blp_pkg, blp_step
// and blp_out_reg.
module battery_level_line_parser_top #(
    parameter int LINE_CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_present,
    output logic [6:0] o_percent,
    output logic       o_charging,
    output logic       o_line_accepted,
    output logic       o_first_detection
);

    localparam int LEN_W = $clog2(LINE_CAPACITY);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic [LEN_W-1:0]      r_len;
    blp_pkg::t_parse_state r_ps;
    blp_pkg::t_store       r_store;
    logic [LEN_W-1:0]      n_len;
    blp_pkg::t_parse_state n_ps;
    blp_pkg::t_store       n_store;
    blp_pkg::t_result      step_result;
    blp_pkg::t_result      out_result;
    logic                  out_can_load;
    logic                  fire;

    assign fire    = r_in_valid && out_can_load;
    assign o_ready = !r_in_valid || fire;

    // Input register: take a request when empty or whenever the held one moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    blp_step #(
        .LINE_CAPACITY (LINE_CAPACITY),
        .LEN_W         (LEN_W)
    ) u_step (
        .i_byte   (r_in_byte),
        .i_len    (r_len),
        .i_ps     (r_ps),
        .i_store  (r_store),
        .o_len    (n_len),
        .o_ps     (n_ps),
        .o_store  (n_store),
        .o_result (step_result)
    );

    // Advance line state and stored report as each byte passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_ps    <= blp_pkg::PARSE_IDLE;
            r_store <= '0;
        end else if (fire) begin
            r_len   <= n_len;
            r_ps    <= n_ps;
            r_store <= n_store;
        end
    end

    blp_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_result   (step_result),
        .o_can_load (out_can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (out_result)
    );

    assign o_present         = out_result.store.present;
    assign o_percent         = out_result.store.percent;
    assign o_charging        = out_result.store.charging;
    assign o_line_accepted   = out_result.line_accepted;
    assign o_first_detection = out_result.first_detection;

endmodule

// ----- rtl/core/blp_checker.sv -----
// Battery level line parser: port-level checks on the result channel,
// bound to battery_level_line_parser_top. No package dependency.
module blp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [7:0] i_rx_byte,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_present,
    input logic [6:0] o_percent,
    input logic       o_charging,
    input logic       o_line_accepted,
    input logic       o_first_detection
);

    // First detection only comes with an accepted line
    a_first_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_first_detection |-> o_line_accepted)
        else $error("first detection without accepted line");

    // An accepted line leaves a present, in-range level
    a_accept_sets_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_line_accepted |-> o_present && (o_percent <= 7'd100))
        else $error("accepted line without valid stored report");

    // Before any report, level and flag read zero
    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_present |-> (o_percent == 7'd0) && !o_charging)
        else $error("stored report nonzero while not present");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_percent) && $stable(o_present)
            && $stable(o_line_accepted))
        else $error("result changed while stalled");

endmodule

bind battery_level_line_parser_top blp_checker u_blp_checker (.*);
